// ----- rtl/sic_pkg.sv -----
// Package with the word types, widths and relation codes of the segment intersection classifier.
`default_nettype none

package sic_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int OUT_BITS   = COORD_BITS + FRAC_BITS;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    localparam int CROSS_BITS = 2 * COORD_BITS + 3;
    localparam int MAG_BITS   = 2 * COORD_BITS + 2;
    localparam int HALF_BITS  = MAG_BITS / 2;
    localparam int HI_BITS    = MAG_BITS - HALF_BITS;
    localparam int NUM_BITS   = DIFF_BITS + MAG_BITS;
    localparam int QUO_BITS   = DIFF_BITS + FRAC_BITS;

    typedef enum logic [1:0] {
        REL_CROSS     = 2'd0,
        REL_PARALLEL  = 2'd1,
        REL_COLLINEAR = 2'd2,
        REL_NONE      = 2'd3
    } rel_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] first_start_x;
        logic signed [COORD_BITS-1:0] first_start_y;
        logic signed [COORD_BITS-1:0] first_end_x;
        logic signed [COORD_BITS-1:0] first_end_y;
        logic signed [COORD_BITS-1:0] second_start_x;
        logic signed [COORD_BITS-1:0] second_start_y;
        logic signed [COORD_BITS-1:0] second_end_x;
        logic signed [COORD_BITS-1:0] second_end_y;
    } in_word_t;

    typedef struct packed {
        rel_t                       relation;
        logic signed [OUT_BITS-1:0] cross_x;
        logic signed [OUT_BITS-1:0] cross_y;
    } out_word_t;

    typedef struct packed {
        rel_t                         rel;
        logic                         do_div;
        logic signed [COORD_BITS-1:0] base_x;
        logic signed [COORD_BITS-1:0] base_y;
        logic [DIFF_BITS-1:0]         dlt_x;
        logic [DIFF_BITS-1:0]         dlt_y;
        logic [MAG_BITS-1:0]          d1_mag;
        logic [MAG_BITS-1:0]          d5_mag;
        logic                         neg_x;
        logic                         neg_y;
    } job_t;

endpackage

`default_nettype wire

// ----- rtl/sic_front.sv -----
// Front pipeline: differences, cross products and classification of each segment pair.
`default_nettype none

module sic_front
    import sic_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire in_word_t in_word,
    output logic          job_valid,
    input  wire logic     job_ready,
    output job_t          job
);

    function automatic logic signed [DIFF_BITS-1:0] sub(
        input logic signed [COORD_BITS-1:0] u,
        input logic signed [COORD_BITS-1:0] v
    );
        return DIFF_BITS'(u) - DIFF_BITS'(v);
    endfunction

    function automatic logic signed [CROSS_BITS-1:0] diff_prod(
        input logic signed [PROD_BITS-1:0] p,
        input logic signed [PROD_BITS-1:0] q
    );
        return CROSS_BITS'(p) - CROSS_BITS'(q);
    endfunction

    function automatic logic [MAG_BITS-1:0] mag(input logic signed [CROSS_BITS-1:0] v);
        logic signed [CROSS_BITS-1:0] n;
        n = -v;
        return v[CROSS_BITS-1] ? n[MAG_BITS-1:0] : v[MAG_BITS-1:0];
    endfunction

    function automatic logic [DIFF_BITS-1:0] dmag(input logic signed [DIFF_BITS-1:0] v);
        return v[DIFF_BITS-1] ? DIFF_BITS'(-v) : DIFF_BITS'(v);
    endfunction

    function automatic logic in_box(
        input logic signed [COORD_BITS-1:0] px,
        input logic signed [COORD_BITS-1:0] py,
        input logic signed [COORD_BITS-1:0] ux,
        input logic signed [COORD_BITS-1:0] uy,
        input logic signed [COORD_BITS-1:0] vx,
        input logic signed [COORD_BITS-1:0] vy
    );
        logic signed [COORD_BITS-1:0] lx;
        logic signed [COORD_BITS-1:0] hx;
        logic signed [COORD_BITS-1:0] ly;
        logic signed [COORD_BITS-1:0] hy;
        lx = (ux < vx) ? ux : vx;
        hx = (ux < vx) ? vx : ux;
        ly = (uy < vy) ? uy : vy;
        hy = (uy < vy) ? vy : uy;
        return (lx <= px) && (px <= hx) && (ly <= py) && (py <= hy);
    endfunction

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv;

    in_word_t c1_reg, c2_reg, c3_reg;
    logic signed [DIFF_BITS-1:0] adx1_reg, ady1_reg, bdx1_reg, bdy1_reg;
    logic signed [DIFF_BITS-1:0] ex1_reg, ey1_reg, fx1_reg, fy1_reg;
    logic signed [DIFF_BITS-1:0] gx1_reg, gy1_reg, hx1_reg, hy1_reg;
    logic signed [DIFF_BITS-1:0] adx2_reg, ady2_reg, adx3_reg, ady3_reg;

    logic signed [PROD_BITS-1:0] p1a_reg, p1b_reg, p2a_reg, p2b_reg, p3a_reg;
    logic signed [PROD_BITS-1:0] p3b_reg, p4a_reg, p4b_reg, p5a_reg, p5b_reg;
    logic [3:0] box2_reg, box3_reg;

    logic signed [CROSS_BITS-1:0] d1_reg, d2_reg, d3_reg, d4_reg, d5_reg;

    job_t job_reg, job_next;

    logic z1, z2, z3, z4, z5, n1, n2, n3, n4, n5, proper;

    assign adv       = !v4_reg || job_ready;
    assign in_ready  = adv;
    assign job_valid = v4_reg;
    assign job       = job_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1_reg   <= in_word;
            adx1_reg <= sub(in_word.first_end_x, in_word.first_start_x);
            ady1_reg <= sub(in_word.first_end_y, in_word.first_start_y);
            bdx1_reg <= sub(in_word.second_end_x, in_word.second_start_x);
            bdy1_reg <= sub(in_word.second_end_y, in_word.second_start_y);
            ex1_reg  <= sub(in_word.first_start_x, in_word.second_start_x);
            ey1_reg  <= sub(in_word.first_start_y, in_word.second_start_y);
            fx1_reg  <= sub(in_word.first_end_x, in_word.second_start_x);
            fy1_reg  <= sub(in_word.first_end_y, in_word.second_start_y);
            gx1_reg  <= sub(in_word.second_start_x, in_word.first_start_x);
            gy1_reg  <= sub(in_word.second_start_y, in_word.first_start_y);
            hx1_reg  <= sub(in_word.second_end_x, in_word.first_start_x);
            hy1_reg  <= sub(in_word.second_end_y, in_word.first_start_y);

            c2_reg   <= c1_reg;
            adx2_reg <= adx1_reg;
            ady2_reg <= ady1_reg;
            p1a_reg  <= bdx1_reg * ey1_reg;
            p1b_reg  <= bdy1_reg * ex1_reg;
            p2a_reg  <= bdx1_reg * fy1_reg;
            p2b_reg  <= bdy1_reg * fx1_reg;
            p3a_reg  <= adx1_reg * gy1_reg;
            p3b_reg  <= ady1_reg * gx1_reg;
            p4a_reg  <= adx1_reg * hy1_reg;
            p4b_reg  <= ady1_reg * hx1_reg;
            p5a_reg  <= adx1_reg * bdy1_reg;
            p5b_reg  <= ady1_reg * bdx1_reg;
            box2_reg[0] <= in_box(c1_reg.first_start_x, c1_reg.first_start_y,
                                  c1_reg.second_start_x, c1_reg.second_start_y,
                                  c1_reg.second_end_x, c1_reg.second_end_y);
            box2_reg[1] <= in_box(c1_reg.first_end_x, c1_reg.first_end_y,
                                  c1_reg.second_start_x, c1_reg.second_start_y,
                                  c1_reg.second_end_x, c1_reg.second_end_y);
            box2_reg[2] <= in_box(c1_reg.second_start_x, c1_reg.second_start_y,
                                  c1_reg.first_start_x, c1_reg.first_start_y,
                                  c1_reg.first_end_x, c1_reg.first_end_y);
            box2_reg[3] <= in_box(c1_reg.second_end_x, c1_reg.second_end_y,
                                  c1_reg.first_start_x, c1_reg.first_start_y,
                                  c1_reg.first_end_x, c1_reg.first_end_y);

            c3_reg   <= c2_reg;
            adx3_reg <= adx2_reg;
            ady3_reg <= ady2_reg;
            box3_reg <= box2_reg;
            d1_reg   <= diff_prod(p1a_reg, p1b_reg);
            d2_reg   <= diff_prod(p2a_reg, p2b_reg);
            d3_reg   <= diff_prod(p3a_reg, p3b_reg);
            d4_reg   <= diff_prod(p4a_reg, p4b_reg);
            d5_reg   <= diff_prod(p5a_reg, p5b_reg);

            job_reg  <= job_next;
        end
    end

    assign z1 = (d1_reg == '0);
    assign z2 = (d2_reg == '0);
    assign z3 = (d3_reg == '0);
    assign z4 = (d4_reg == '0);
    assign z5 = (d5_reg == '0);
    assign n1 = d1_reg[CROSS_BITS-1];
    assign n2 = d2_reg[CROSS_BITS-1];
    assign n3 = d3_reg[CROSS_BITS-1];
    assign n4 = d4_reg[CROSS_BITS-1];
    assign n5 = d5_reg[CROSS_BITS-1];
    assign proper = ((!z1 && !n1 && n2) || (n1 && !z2 && !n2)) &&
                    ((!z3 && !n3 && n4) || (n3 && !z4 && !n4));

    always_comb
    begin
        job_next        = '0;
        job_next.rel    = REL_NONE;
        job_next.d1_mag = mag(d1_reg);
        job_next.d5_mag = mag(d5_reg);
        job_next.neg_x  = adx3_reg[DIFF_BITS-1] ^ n1 ^ n5;
        job_next.neg_y  = ady3_reg[DIFF_BITS-1] ^ n1 ^ n5;
        if (z5)
        begin
            job_next.rel = z1 ? REL_COLLINEAR : REL_PARALLEL;
        end
        else if (proper)
        begin
            job_next.rel    = REL_CROSS;
            job_next.do_div = 1'b1;
            job_next.base_x = c3_reg.first_start_x;
            job_next.base_y = c3_reg.first_start_y;
            job_next.dlt_x  = dmag(adx3_reg);
            job_next.dlt_y  = dmag(ady3_reg);
        end
        else if (z1 && box3_reg[0])
        begin
            job_next.rel    = REL_CROSS;
            job_next.base_x = c3_reg.first_start_x;
            job_next.base_y = c3_reg.first_start_y;
        end
        else if (z2 && box3_reg[1])
        begin
            job_next.rel    = REL_CROSS;
            job_next.base_x = c3_reg.first_end_x;
            job_next.base_y = c3_reg.first_end_y;
        end
        else if (z3 && box3_reg[2])
        begin
            job_next.rel    = REL_CROSS;
            job_next.base_x = c3_reg.second_start_x;
            job_next.base_y = c3_reg.second_start_y;
        end
        else if (z4 && box3_reg[3])
        begin
            job_next.rel    = REL_CROSS;
            job_next.base_x = c3_reg.second_end_x;
            job_next.base_y = c3_reg.second_end_y;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/sic_queue.sv -----
// Small register queue that decouples the front pipeline from the back pipeline.
`default_nettype none

module sic_queue
    import sic_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  wire job_t push_job,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output job_t      pop_job
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic push, pop;

    assign push_ready = (cnt_reg != CNT_W'(DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_job    = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/sic_back.sv -----
// Back pipeline: split multiply, one-bit-per-stage divider and fixed-point point assembly.
`default_nettype none

module sic_back
    import sic_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic job_valid,
    output logic      job_ready,
    input  wire job_t job,
    output logic      out_valid,
    input  wire logic out_ready,
    output out_word_t out_word
);

    typedef struct packed {
        rel_t                         rel;
        logic                         do_div;
        logic signed [COORD_BITS-1:0] base_x;
        logic signed [COORD_BITS-1:0] base_y;
        logic                         neg_x;
        logic                         neg_y;
        logic [MAG_BITS-1:0]          dv;
        logic [MAG_BITS-1:0]          rx;
        logic [MAG_BITS-1:0]          ry;
        logic [QUO_BITS-1:0]          nx;
        logic [QUO_BITS-1:0]          ny;
    } div_t;

    function automatic logic [MAG_BITS+QUO_BITS-1:0] div_bit(
        input logic [MAG_BITS-1:0] r,
        input logic [QUO_BITS-1:0] n,
        input logic [MAG_BITS-1:0] d
    );
        logic [MAG_BITS:0] t;
        logic              qb;
        t  = {r, n[QUO_BITS-1]};
        qb = (t >= {1'b0, d});
        if (qb)
        begin
            t = t - {1'b0, d};
        end
        return {t[MAG_BITS-1:0], n[QUO_BITS-2:0], qb};
    endfunction

    function automatic div_t div_step(input div_t s);
        div_t o;
        o = s;
        {o.rx, o.nx} = div_bit(s.rx, s.nx, s.dv);
        {o.ry, o.ny} = div_bit(s.ry, s.ny, s.dv);
        return o;
    endfunction

    function automatic logic signed [OUT_BITS-1:0] place(
        input logic signed [COORD_BITS-1:0] base,
        input logic [QUO_BITS-1:0]          q,
        input logic                         neg,
        input logic                         use_q
    );
        logic signed [OUT_BITS-1:0] b;
        logic [OUT_BITS-1:0]        qv;
        b  = OUT_BITS'(base) << FRAC_BITS;
        qv = use_q ? q[OUT_BITS-1:0] : '0;
        return neg ? b - qv : b + qv;
    endfunction

    logic adv;
    logic v1_reg, vo_reg;
    logic [QUO_BITS:0] sv_reg;

    job_t j1_reg;
    logic [DIFF_BITS+HALF_BITS-1:0] plx_reg, ply_reg;
    logic [DIFF_BITS+HI_BITS-1:0]   phx_reg, phy_reg;
    logic [NUM_BITS-1:0]            prod_x, prod_y;

    div_t stg_reg [QUO_BITS+1];
    div_t init_next;
    out_word_t out_reg;

    assign adv       = !vo_reg || out_ready;
    assign job_ready = adv;
    assign out_valid = vo_reg;
    assign out_word  = out_reg;

    assign prod_x = NUM_BITS'(plx_reg) + (NUM_BITS'(phx_reg) << HALF_BITS);
    assign prod_y = NUM_BITS'(ply_reg) + (NUM_BITS'(phy_reg) << HALF_BITS);

    always_comb
    begin
        init_next        = '0;
        init_next.rel    = j1_reg.rel;
        init_next.do_div = j1_reg.do_div;
        init_next.base_x = j1_reg.base_x;
        init_next.base_y = j1_reg.base_y;
        init_next.neg_x  = j1_reg.neg_x;
        init_next.neg_y  = j1_reg.neg_y;
        init_next.dv     = j1_reg.d5_mag;
        init_next.rx     = prod_x[NUM_BITS-1:DIFF_BITS];
        init_next.ry     = prod_y[NUM_BITS-1:DIFF_BITS];
        init_next.nx     = QUO_BITS'(prod_x[DIFF_BITS-1:0]) << FRAC_BITS;
        init_next.ny     = QUO_BITS'(prod_y[DIFF_BITS-1:0]) << FRAC_BITS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            sv_reg <= '0;
            vo_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= job_valid;
            sv_reg <= {sv_reg[QUO_BITS-1:0], v1_reg};
            vo_reg <= sv_reg[QUO_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            j1_reg  <= job;
            plx_reg <= job.dlt_x * job.d1_mag[HALF_BITS-1:0];
            ply_reg <= job.dlt_y * job.d1_mag[HALF_BITS-1:0];
            phx_reg <= job.dlt_x * job.d1_mag[MAG_BITS-1:HALF_BITS];
            phy_reg <= job.dlt_y * job.d1_mag[MAG_BITS-1:HALF_BITS];
            stg_reg[0] <= init_next;
            for (int k = 1; k <= QUO_BITS; k++)
            begin
                stg_reg[k] <= div_step(stg_reg[k-1]);
            end
            out_reg.relation <= stg_reg[QUO_BITS].rel;
            out_reg.cross_x  <= place(stg_reg[QUO_BITS].base_x, stg_reg[QUO_BITS].nx,
                                      stg_reg[QUO_BITS].neg_x, stg_reg[QUO_BITS].do_div);
            out_reg.cross_y  <= place(stg_reg[QUO_BITS].base_y, stg_reg[QUO_BITS].ny,
                                      stg_reg[QUO_BITS].neg_y, stg_reg[QUO_BITS].do_div);
        end
    end

endmodule

`default_nettype wire

// ----- rtl/segment_intersection_classifier_unit.sv -----
// Top level of the segment intersection classifier: front pipeline, queue and back pipeline.
// An accepted word reaches its result through the four front stages, the queue and one back
// stage per quotient bit.
// Throughput: one word per cycle, sustained, while the output side takes results.
// Reset: rst_n clears all valid flags and queue pointers at once; the unit is ready right away.
`default_nettype none

module segment_intersection_classifier_unit
    import sic_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_word_t  in_word,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_word_t      out_word
);

    logic f_valid, f_ready, b_valid, b_ready;
    job_t f_job, b_job;

    sic_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .job_valid (f_valid),
        .job_ready (f_ready),
        .job       (f_job)
    );

    sic_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_job   (f_job),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_job    (b_job)
    );

    sic_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (b_valid),
        .job_ready (b_ready),
        .job       (b_job),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

endmodule

`default_nettype wire

// ----- rtl/sic_checker.sv -----
// Port-level checker for the segment intersection classifier and its bind statement.
`default_nettype none

module sic_checker
    import sic_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      out_valid,
    input wire logic      out_ready,
    input wire out_word_t out_word
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("Output word changed or dropped while stalled.");

    a_no_point: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_word.relation != REL_CROSS) |->
            (out_word.cross_x == '0) && (out_word.cross_y == '0))
        else $error("Nonzero point on a word without intersection.");

    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("Output valid right after reset.");

endmodule

bind segment_intersection_classifier_unit sic_checker u_chk (.*);

`default_nettype wire
